// ===== rtl/rtts_pkg.sv =====
`timescale 1ns / 1ps

package rtts_pkg;

    // Event kinds carried in the slave-side tuser.
    localparam logic [1:0] EV_START   = 2'd0;
    localparam logic [1:0] EV_SENT    = 2'd1;
    localparam logic [1:0] EV_REPLY   = 2'd2;
    localparam logic [1:0] EV_TIMEOUT = 2'd3;

    // Message kinds carried in the master-side tuser.
    localparam logic [1:0] TX_NONE    = 2'd0;
    localparam logic [1:0] TX_COMMAND = 2'd1;
    localparam logic [1:0] TX_STAMP   = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_RUNNING   = 3'd0;
    localparam logic [2:0] ST_COMPLETED = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_WRONG     = 3'd3;
    localparam logic [2:0] ST_TIMEOUT   = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MEASURE_ROUNDS = 3'd0;
    localparam logic [2:0] CFG_COMP_RETRIES   = 3'd1;
    localparam logic [2:0] CFG_THR_FACTOR     = 3'd2;
    localparam logic [2:0] CFG_MSG_TYPE       = 3'd3;
    localparam logic [2:0] CFG_ACK_CODE       = 3'd4;
    localparam logic [2:0] CFG_START_CODE     = 3'd5;
    localparam logic [2:0] CFG_STAMP_CODE     = 3'd6;
    localparam logic [2:0] CFG_GOOD_CODE      = 3'd7;

    localparam logic [31:0] MIN_RT_RESET = 32'hFFFF_FFFF;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_START_ACK = 5'b00010,
        PH_MEASURE   = 5'b00100,
        PH_COMP      = 5'b01000,
        PH_STOP_ACK  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] measure_rounds;
        logic [7:0] compensated_retries;
        logic [7:0] threshold_factor;
        logic [7:0] message_type_code;
        logic [7:0] ack_code;
        logic [7:0] start_code;
        logic [7:0] timestamp_code;
        logic [7:0] good_code;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_us;
        logic [7:0]  rx_command;
        logic [7:0]  target_device;
    } t_item;

    typedef struct packed {
        logic [1:0]  tx_kind;
        logic [7:0]  tx_type;
        logic [7:0]  tx_command;
        logic [7:0]  tx_sequence;
        logic [31:0] tx_stamp;
        logic [7:0]  tx_device;
        logic [2:0]  status;
    } t_result;

endpackage

// ===== rtl/rtts_ctrl.sv =====
`timescale 1ns / 1ps

module rtts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  rtts_pkg::t_item  i_item,
    input  rtts_pkg::t_cfg   i_cfg,
    output logic             o_produce,
    output rtts_pkg::t_result o_result
);

    rtts_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_send_count, n_send_count;
    logic [31:0] r_last_sent, n_last_sent;
    logic [31:0] r_min_rt, n_min_rt;
    logic [31:0] r_threshold, n_threshold;
    logic [7:0]  r_device, n_device;

    logic [31:0] rt;
    logic [31:0] min_cand;
    logic [39:0] product;
    logic [31:0] thr_new;
    logic [7:0]  count_inc;

    assign rt        = i_item.now_us - r_last_sent;
    assign min_cand  = (rt < r_min_rt) ? rt : r_min_rt;
    assign product   = {8'd0, min_cand} * {32'd0, i_cfg.threshold_factor};
    // Q4.4 scaling drops four fraction bits; anything left above bit 35 saturates.
    assign thr_new   = (product[39:36] != 4'd0) ? 32'hFFFF_FFFF : product[35:4];
    assign count_inc = r_send_count + 8'd1;

    always_comb begin
        logic [1:0]  k;
        logic [7:0]  cmd;
        logic [7:0]  seq;
        logic [31:0] stamp;
        logic [2:0]  st;
        k            = rtts_pkg::TX_NONE;
        cmd          = 8'd0;
        seq          = 8'd0;
        stamp        = 32'd0;
        st           = rtts_pkg::ST_RUNNING;
        o_produce    = 1'b0;
        n_phase      = r_phase;
        n_send_count = r_send_count;
        n_last_sent  = r_last_sent;
        n_min_rt     = r_min_rt;
        n_threshold  = r_threshold;
        n_device     = r_device;

        unique case (i_item.kind)
            rtts_pkg::EV_START: begin
                n_device     = i_item.target_device;
                n_phase      = rtts_pkg::PH_START_ACK;
                n_send_count = 8'd0;
                n_min_rt     = rtts_pkg::MIN_RT_RESET;
                o_produce    = 1'b1;
                k            = rtts_pkg::TX_COMMAND;
                cmd          = i_cfg.start_code;
            end
            rtts_pkg::EV_SENT: begin
                n_last_sent = i_item.now_us;
            end
            rtts_pkg::EV_TIMEOUT: begin
                if (r_phase != rtts_pkg::PH_IDLE) begin
                    n_phase   = rtts_pkg::PH_IDLE;
                    o_produce = 1'b1;
                    st        = rtts_pkg::ST_TIMEOUT;
                end
            end
            rtts_pkg::EV_REPLY: begin
                unique case (r_phase)
                    rtts_pkg::PH_START_ACK: begin
                        o_produce = 1'b1;
                        if (i_item.rx_command != i_cfg.ack_code) begin
                            n_phase = rtts_pkg::PH_IDLE;
                            st      = rtts_pkg::ST_WRONG;
                        end else begin
                            n_phase      = rtts_pkg::PH_MEASURE;
                            n_send_count = count_inc;
                            k            = rtts_pkg::TX_STAMP;
                            cmd          = i_cfg.timestamp_code;
                            seq          = count_inc;
                            stamp        = i_item.now_us;
                        end
                    end
                    rtts_pkg::PH_MEASURE: begin
                        o_produce = 1'b1;
                        n_min_rt  = min_cand;
                        k         = rtts_pkg::TX_STAMP;
                        cmd       = i_cfg.timestamp_code;
                        if (r_send_count == i_cfg.measure_rounds) begin
                            // The count restarts and the first compensated send is number one.
                            n_threshold  = thr_new;
                            n_phase      = rtts_pkg::PH_COMP;
                            n_send_count = 8'd1;
                            seq          = 8'd1;
                            stamp        = i_item.now_us + {1'b0, thr_new[31:1]};
                        end else begin
                            n_send_count = count_inc;
                            seq          = count_inc;
                            stamp        = i_item.now_us;
                        end
                    end
                    rtts_pkg::PH_COMP: begin
                        o_produce = 1'b1;
                        if (rt < r_threshold) begin
                            n_phase      = rtts_pkg::PH_STOP_ACK;
                            n_send_count = 8'd0;
                            k            = rtts_pkg::TX_COMMAND;
                            cmd          = i_cfg.good_code;
                        end else if (r_send_count == i_cfg.compensated_retries) begin
                            n_send_count = 8'd0;
                            n_phase      = rtts_pkg::PH_IDLE;
                            st           = rtts_pkg::ST_EXHAUSTED;
                        end else begin
                            n_send_count = count_inc;
                            k            = rtts_pkg::TX_STAMP;
                            cmd          = i_cfg.timestamp_code;
                            seq          = count_inc;
                            stamp        = i_item.now_us + {1'b0, r_threshold[31:1]};
                        end
                    end
                    rtts_pkg::PH_STOP_ACK: begin
                        o_produce = 1'b1;
                        n_phase   = rtts_pkg::PH_IDLE;
                        st        = (i_item.rx_command != i_cfg.ack_code) ?
                                    rtts_pkg::ST_WRONG : rtts_pkg::ST_COMPLETED;
                    end
                    default: begin
                        n_phase = rtts_pkg::PH_IDLE;
                    end
                endcase
            end
        endcase

        o_result.tx_kind     = k;
        o_result.tx_type     = (k != rtts_pkg::TX_NONE) ? i_cfg.message_type_code : 8'd0;
        o_result.tx_command  = cmd;
        o_result.tx_sequence = seq;
        o_result.tx_stamp    = stamp;
        o_result.tx_device   = (k != rtts_pkg::TX_NONE) ? n_device : 8'd0;
        o_result.status      = st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= rtts_pkg::PH_IDLE;
            r_send_count <= 8'd0;
            r_last_sent  <= 32'd0;
            r_min_rt     <= rtts_pkg::MIN_RT_RESET;
            r_threshold  <= 32'd0;
            r_device     <= 8'd0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_send_count <= n_send_count;
            r_last_sent  <= n_last_sent;
            r_min_rt     <= n_min_rt;
            r_threshold  <= n_threshold;
            r_device     <= n_device;
        end
    end

    // Every failure or completion report leaves the exchange idle.
    a_report_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_produce && o_result.status != rtts_pkg::ST_RUNNING)
        |=> (r_phase == rtts_pkg::PH_IDLE))
        else $error("report did not return the exchange to idle");

    // A message on the wire always reports a running exchange.
    a_send_is_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_produce && o_result.tx_kind != rtts_pkg::TX_NONE)
        |-> (o_result.status == rtts_pkg::ST_RUNNING))
        else $error("message sent together with a final status");

    // A start restarts the measurement state.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.kind == rtts_pkg::EV_START)
        |=> (r_send_count == 8'd0 && r_min_rt == rtts_pkg::MIN_RT_RESET))
        else $error("start did not clear the measurement state");

endmodule

// ===== rtl/rtts_obuf.sv =====
`timescale 1ns / 1ps

module rtts_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rtts_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output rtts_pkg::t_result o_data
);

    logic              r_main_valid;
    logic              r_skid_valid;
    rtts_pkg::t_result r_main;
    rtts_pkg::t_result r_skid;
    logic              pop;

    assign pop     = r_main_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push && (!r_main_valid || pop)) begin
            r_main       <= i_data;
            r_main_valid <= 1'b1;
        end else if (i_push) begin
            r_skid       <= i_data;
            r_skid_valid <= 1'b1;
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // The skid word only ever sits behind an occupied output word.
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid word held with an empty output word");

endmodule

// ===== rtl/round_trip_time_sync_master_core.sv =====
`timescale 1ns / 1ps

// Master side of a round-trip time synchronization exchange.
// The slave-side stream carries one event word per transfer: the event kind in
// s_axis_tuser (start, message sent, reply arrived, timeout) and the current
// microsecond time, the reply command byte and the target device in s_axis_tdata.
// The master-side stream carries at most one result word per event: the kind of
// message to transmit in m_axis_tuser and the message bytes plus status in
// m_axis_tdata. Message-sent events and events ignored while idle produce no word.
// Configuration registers are written through the plain write port. The user is
// to write them only while no event is in flight; the block does not enforce it.
// An accepted event is captured in an input register and processed by the exchange
// controller (round-trip subtract, minimum compare and one 32x8 threshold multiply)
// once the output buffer has room; its result word is registered into the output
// buffer, which drives the master side. One event is accepted every cycle when the
// receiver keeps up; the controller updates its state as each held event fires.
// A two-word output buffer absorbs a stall: once both words are held and an event
// waits in the input register, s_axis_tready drops until the cycle after the
// receiver takes a word, and nothing is lost or reordered.
// Synchronous active-low reset empties the input register and the output buffer,
// returns the exchange to idle and loads the register defaults.

module round_trip_time_sync_master_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: now_us[31:0], rx_command[39:32], target_device[47:40]
    input  logic [47:0] s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: tx_type[7:0], tx_command[15:8], tx_sequence[23:16], tx_stamp[55:24],
    //        tx_device[63:56], status[66:64], zero padding[71:67]
    output logic [71:0] m_axis_tdata,
    // tuser: tx_kind[1:0]
    output logic [1:0]  m_axis_tuser
);

    rtts_pkg::t_cfg    r_cfg;
    rtts_pkg::t_item   r_item;
    logic              r_item_valid;
    logic              fire;
    logic              produce;
    logic              obuf_space;
    rtts_pkg::t_result step_result;
    rtts_pkg::t_result out_result;

    // Configuration registers, one per index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.measure_rounds      <= 8'd8;
            r_cfg.compensated_retries <= 8'd8;
            r_cfg.threshold_factor    <= 8'd24;
            r_cfg.message_type_code   <= 8'd1;
            r_cfg.ack_code            <= 8'd2;
            r_cfg.start_code          <= 8'd3;
            r_cfg.timestamp_code      <= 8'd4;
            r_cfg.good_code           <= 8'd5;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rtts_pkg::CFG_MEASURE_ROUNDS: r_cfg.measure_rounds      <= i_cfg_data;
                rtts_pkg::CFG_COMP_RETRIES:   r_cfg.compensated_retries <= i_cfg_data;
                rtts_pkg::CFG_THR_FACTOR:     r_cfg.threshold_factor    <= i_cfg_data;
                rtts_pkg::CFG_MSG_TYPE:       r_cfg.message_type_code   <= i_cfg_data;
                rtts_pkg::CFG_ACK_CODE:       r_cfg.ack_code            <= i_cfg_data;
                rtts_pkg::CFG_START_CODE:     r_cfg.start_code          <= i_cfg_data;
                rtts_pkg::CFG_STAMP_CODE:     r_cfg.timestamp_code      <= i_cfg_data;
                rtts_pkg::CFG_GOOD_CODE:      r_cfg.good_code           <= i_cfg_data;
            endcase
        end
    end

    // The held event is processed whenever the output buffer has room for a word.
    // The buffer's room flag is registered, so tready has no path from m_axis_tready.
    assign fire          = r_item_valid && obuf_space;
    assign s_axis_tready = !r_item_valid || obuf_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_item_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.kind          <= s_axis_tuser;
            r_item.now_us        <= s_axis_tdata[31:0];
            r_item.rx_command    <= s_axis_tdata[39:32];
            r_item.target_device <= s_axis_tdata[47:40];
        end
    end

    rtts_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_item),
        .i_cfg     (r_cfg),
        .o_produce (produce),
        .o_result  (step_result)
    );

    rtts_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire && produce),
        .i_data  (step_result),
        .o_space (obuf_space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_result)
    );

    assign m_axis_tuser = out_result.tx_kind;
    assign m_axis_tdata = {5'd0,
                           out_result.status,
                           out_result.tx_device,
                           out_result.tx_stamp,
                           out_result.tx_sequence,
                           out_result.tx_command,
                           out_result.tx_type};

    // A held event that is blocked stays blocked until the buffer frees a word.
    a_blocked_event_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_valid && !obuf_space) |=> r_item_valid)
        else $error("blocked event dropped from the input register");

endmodule

// ===== tb/sv/round_trip_time_sync_master_core_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the round-trip time sync master core. An initial
// block fills a queue of event words. A clocked driver offers them on the
// slave-side stream. A clocked monitor takes result words on the master side
// and compares each one with the oldest word that the bench's own model of the
// exchange predicted when the matching event was accepted.
module round_trip_time_sync_master_core_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: now_us[31:0], rx_command[39:32], target_device[47:40]
    logic [47:0] s_axis_tdata = '0;
    // tuser: kind[1:0]
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: tx_type[7:0], tx_command[15:8], tx_sequence[23:16], tx_stamp[55:24],
    //        tx_device[63:56], status[66:64], zero padding[71:67]
    logic [71:0] m_axis_tdata;
    // tuser: tx_kind[1:0]
    logic [1:0]  m_axis_tuser;

    round_trip_time_sync_master_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run, including every long stall.
    initial begin
        #(64'd20_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // Event words waiting to be offered, and result words still owed by the core.
    rtts_pkg::t_item   events_to_send[$];
    rtts_pkg::t_result words_due[$];

    // The bench's own copy of the exchange state and of the register file.
    rtts_pkg::t_cfg    regs = '{8'd8, 8'd8, 8'd24, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5};
    rtts_pkg::t_phase  sync_phase = rtts_pkg::PH_IDLE;
    logic [7:0]  round_count = '0;
    logic [31:0] sent_at = '0;
    logic [31:0] best_round_trip = rtts_pkg::MIN_RT_RESET;
    logic [31:0] accept_limit = '0;
    logic [7:0]  sync_device = '0;

    // Bookkeeping.
    int     events_queued = 0;
    int     events_accepted = 0;
    int     words_checked = 0;
    int     mismatches = 0;
    int     phases_run = 0;
    int     seen_completed = 0;
    int     seen_exhausted = 0;
    int     seen_wrong = 0;
    int     seen_timeout = 0;
    logic [31:0] sim_us = '0;
    bit     noise_on = 1'b1;

    // Driver and monitor pacing.
    rtts_pkg::t_item   offered;
    int     send_gap = 0;
    int     send_quiet = 0;
    int     recv_hold = 0;
    int     recv_quiet = 0;
    int     next_long_hold = 150;
    rtts_pkg::t_result want, got;

    // Idle lengths: mostly short, now and then a long one.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic rtts_pkg::t_result make_word(input logic [1:0] kind,
                                                    input logic [7:0] cmd,
                                                    input logic [7:0] seq,
                                                    input logic [31:0] stamp,
                                                    input logic [2:0] status);
        rtts_pkg::t_result w;
        w.tx_kind     = kind;
        w.tx_type     = (kind != rtts_pkg::TX_NONE) ? regs.message_type_code : 8'd0;
        w.tx_command  = cmd;
        w.tx_sequence = seq;
        w.tx_stamp    = stamp;
        w.tx_device   = (kind != rtts_pkg::TX_NONE) ? sync_device : 8'd0;
        w.status      = status;
        return w;
    endfunction

    // Advances the exchange by one accepted event and queues the word it owes.
    task automatic advance_sync(input rtts_pkg::t_item ev);
        logic [31:0]       rtt;
        logic [39:0]       product;
        rtts_pkg::t_result w;
        bit                owes;
        rtt  = ev.now_us - sent_at;
        owes = 1'b1;
        w    = '0;
        case (ev.kind)
            rtts_pkg::EV_START: begin
                // A start restarts the exchange from any phase.
                sync_device     = ev.target_device;
                sync_phase      = rtts_pkg::PH_START_ACK;
                round_count     = 8'd0;
                best_round_trip = rtts_pkg::MIN_RT_RESET;
                w = make_word(rtts_pkg::TX_COMMAND, regs.start_code, 8'd0, 32'd0,
                              rtts_pkg::ST_RUNNING);
            end
            rtts_pkg::EV_SENT: begin
                sent_at = ev.now_us;
                owes    = 1'b0;
            end
            rtts_pkg::EV_TIMEOUT: begin
                if (sync_phase == rtts_pkg::PH_IDLE) begin
                    owes = 1'b0;
                end else begin
                    sync_phase = rtts_pkg::PH_IDLE;
                    w = make_word(rtts_pkg::TX_NONE, 8'd0, 8'd0, 32'd0,
                                  rtts_pkg::ST_TIMEOUT);
                end
            end
            default: begin
                case (sync_phase)
                    rtts_pkg::PH_START_ACK: begin
                        if (ev.rx_command != regs.ack_code) begin
                            sync_phase = rtts_pkg::PH_IDLE;
                            w = make_word(rtts_pkg::TX_NONE, 8'd0, 8'd0, 32'd0,
                                          rtts_pkg::ST_WRONG);
                        end else begin
                            sync_phase  = rtts_pkg::PH_MEASURE;
                            round_count = round_count + 8'd1;
                            w = make_word(rtts_pkg::TX_STAMP, regs.timestamp_code,
                                          round_count, ev.now_us, rtts_pkg::ST_RUNNING);
                        end
                    end
                    rtts_pkg::PH_MEASURE: begin
                        if (rtt < best_round_trip) best_round_trip = rtt;
                        if (round_count == regs.measure_rounds) begin
                            // Q4.4 factor: drop four fraction bits, saturate to 32 bits.
                            product = {8'd0, best_round_trip}
                                      * {32'd0, regs.threshold_factor};
                            accept_limit = (product[39:36] != 4'd0) ? 32'hFFFF_FFFF
                                                                    : product[35:4];
                            round_count = 8'd1;
                            sync_phase  = rtts_pkg::PH_COMP;
                            w = make_word(rtts_pkg::TX_STAMP, regs.timestamp_code,
                                          round_count, ev.now_us + (accept_limit >> 1),
                                          rtts_pkg::ST_RUNNING);
                        end else begin
                            round_count = round_count + 8'd1;
                            w = make_word(rtts_pkg::TX_STAMP, regs.timestamp_code,
                                          round_count, ev.now_us, rtts_pkg::ST_RUNNING);
                        end
                    end
                    rtts_pkg::PH_COMP: begin
                        if (rtt < accept_limit) begin
                            sync_phase  = rtts_pkg::PH_STOP_ACK;
                            round_count = 8'd0;
                            w = make_word(rtts_pkg::TX_COMMAND, regs.good_code, 8'd0,
                                          32'd0, rtts_pkg::ST_RUNNING);
                        end else if (round_count == regs.compensated_retries) begin
                            round_count = 8'd0;
                            sync_phase  = rtts_pkg::PH_IDLE;
                            w = make_word(rtts_pkg::TX_NONE, 8'd0, 8'd0, 32'd0,
                                          rtts_pkg::ST_EXHAUSTED);
                        end else begin
                            round_count = round_count + 8'd1;
                            w = make_word(rtts_pkg::TX_STAMP, regs.timestamp_code,
                                          round_count, ev.now_us + (accept_limit >> 1),
                                          rtts_pkg::ST_RUNNING);
                        end
                    end
                    rtts_pkg::PH_STOP_ACK: begin
                        sync_phase = rtts_pkg::PH_IDLE;
                        w = make_word(rtts_pkg::TX_NONE, 8'd0, 8'd0, 32'd0,
                                      (ev.rx_command != regs.ack_code)
                                      ? rtts_pkg::ST_WRONG : rtts_pkg::ST_COMPLETED);
                    end
                    default: begin
                        // Replies while idle are dropped.
                        owes = 1'b0;
                    end
                endcase
            end
        endcase
        if (owes) words_due.push_back(w);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            // The report is capped so that a badly broken core cannot flood the log.
            if (mismatches < 200)
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Driver: offers the next queued event word when the slot is free and no gap is pending.
    // A word that is waiting for s_axis_tready stays put until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_sync(offered);
                events_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (events_to_send.size() > 0) begin
                    offered = events_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {offered.target_device, offered.rx_command,
                                      offered.now_us};
                    s_axis_tuser  <= offered.kind;
                    // Now and then a stretch of back-to-back words with no gaps.
                    if (send_quiet > 0) begin
                        send_quiet--;
                        send_gap = 0;
                    end else if ($urandom_range(0, 63) == 0) begin
                        send_quiet = 40;
                        send_gap = 0;
                    end else begin
                        send_gap = ($urandom_range(0, 99) < 60) ? 0 : idle_length();
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result word taken on the master side and paces
    // m_axis_tready with random stalls, quiet stretches and a periodic long hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.tx_kind     = m_axis_tuser;
                got.tx_type     = m_axis_tdata[7:0];
                got.tx_command  = m_axis_tdata[15:8];
                got.tx_sequence = m_axis_tdata[23:16];
                got.tx_stamp    = m_axis_tdata[55:24];
                got.tx_device   = m_axis_tdata[63:56];
                got.status      = m_axis_tdata[66:64];
                if (words_due.size() == 0) begin
                    if (mismatches < 200)
                        $display({"%0t ns: unexpected result word, expected none, ",
                                  "actual 0x%0h/0x%0h"},
                                 $time, m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = words_due.pop_front();
                    check_field("tx_kind", want.tx_kind, got.tx_kind);
                    check_field("tx_type", want.tx_type, got.tx_type);
                    check_field("tx_command", want.tx_command, got.tx_command);
                    check_field("tx_sequence", want.tx_sequence, got.tx_sequence);
                    check_field("tx_stamp", want.tx_stamp, got.tx_stamp);
                    check_field("tx_device", want.tx_device, got.tx_device);
                    check_field("status", want.status, got.status);
                    check_field("tdata padding", 32'd0, m_axis_tdata[71:67]);
                    case (want.status)
                        rtts_pkg::ST_COMPLETED: seen_completed++;
                        rtts_pkg::ST_EXHAUSTED: seen_exhausted++;
                        rtts_pkg::ST_WRONG:     seen_wrong++;
                        rtts_pkg::ST_TIMEOUT:   seen_timeout++;
                        default: ;
                    endcase
                end
                words_checked++;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end else if (words_checked >= next_long_hold) begin
                // Long hold-off: the sender keeps offering, so the output
                // buffer fills and the core has to push back on its input.
                next_long_hold += 700;
                recv_hold = 299;
                m_axis_tready <= 1'b0;
            end else if (recv_quiet > 0) begin
                recv_quiet--;
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < 2) begin
                recv_quiet = 60;
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < 25) begin
                recv_hold = idle_length() - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic push_event(input logic [1:0] kind, input logic [31:0] now_us,
                              input logic [7:0] rx, input logic [7:0] target);
        rtts_pkg::t_item ev;
        ev.kind          = kind;
        ev.now_us        = now_us;
        ev.rx_command    = rx;
        ev.target_device = target;
        events_to_send.push_back(ev);
        events_queued++;
    endtask

    // One message-sent event followed by the reply that arrives rtt later,
    // with the occasional stray event in front when noise is enabled.
    task automatic round_trip(input logic [31:0] rtt, input logic [7:0] rx);
        if (noise_on && $urandom_range(0, 49) == 0)
            push_event($urandom_range(0, 3), $urandom(), $urandom_range(0, 255),
                       $urandom_range(0, 255));
        push_event(rtts_pkg::EV_SENT, sim_us, $urandom_range(0, 255),
                   $urandom_range(0, 255));
        sim_us = sim_us + rtt;
        push_event(rtts_pkg::EV_REPLY, sim_us, rx, $urandom_range(0, 255));
        sim_us = sim_us + $urandom_range(0, 300);
    endtask

    function automatic logic [31:0] pick_round_trip();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return $urandom_range(10, 5000);
        if (roll < 70) return $urandom_range(0, 3);
        if (roll < 85) return $urandom_range(32'h0010_0000, 32'h7FFF_FFFF);
        return $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
    endfunction

    // A full exchange with random content: handshake, measurement rounds,
    // compensated sends and the closing acknowledge. The bench works out the
    // threshold itself so that it can steer round trips to either side of it.
    task automatic push_session();
        logic [31:0] base, rtt, least, limit, extra;
        logic [39:0] product;
        int          retries, win_at, attempts;
        base  = pick_round_trip();
        least = rtts_pkg::MIN_RT_RESET;
        sim_us = $urandom();
        push_event(rtts_pkg::EV_START, $urandom(), $urandom_range(0, 255),
                   $urandom_range(0, 255));
        round_trip($urandom_range(0, 5000),
                   ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : regs.ack_code);
        for (int i = 0; i < regs.measure_rounds; i++) begin
            rtt = base + $urandom_range(0, (base >> 2) + 3);
            if (rtt < least) least = rtt;
            round_trip(rtt, $urandom_range(0, 255));
        end
        product = {8'd0, least} * {32'd0, regs.threshold_factor};
        limit   = (product[39:36] != 4'd0) ? 32'hFFFF_FFFF : product[35:4];
        retries = regs.compensated_retries;
        if (limit == 32'hFFFF_FFFF)
            win_at = 1;
        else if (limit == 32'd0)
            win_at = 0;
        else if ($urandom_range(0, 3) == 0)
            win_at = 0;
        else
            win_at = $urandom_range(1, (retries < 5) ? retries : 5);
        // Running a huge retry budget dry takes too long: break off instead.
        attempts = (win_at != 0) ? win_at : ((retries > 16) ? 3 : retries);
        for (int k = 1; k <= attempts; k++) begin
            if (k == win_at) begin
                rtt = ($urandom_range(0, 3) == 0) ? limit - 32'd1
                                                  : $urandom_range(0, limit - 32'd1);
            end else if ($urandom_range(0, 3) == 0) begin
                rtt = limit;
            end else begin
                extra = $urandom_range(0, 1000);
                rtt = (limit > 32'hFFFF_FFFF - extra) ? 32'hFFFF_FFFF : limit + extra;
            end
            round_trip(rtt, $urandom_range(0, 255));
        end
        if (win_at == 0 && retries > 16)
            push_event(rtts_pkg::EV_TIMEOUT, sim_us, $urandom_range(0, 255),
                       $urandom_range(0, 255));
        if (win_at != 0)
            push_event(rtts_pkg::EV_REPLY, sim_us,
                       ($urandom_range(0, 99) < 85) ? regs.ack_code : $urandom_range(0, 255),
                       $urandom_range(0, 255));
    endtask

    // Waits until every queued word is sent and every owed word has arrived,
    // then lets the pipeline settle so a trailing event without a word is done.
    task automatic wait_idle();
        while (events_to_send.size() != 0 || s_axis_tvalid || words_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
    endtask

    task automatic program_regs(input rtts_pkg::t_cfg c);
        write_reg(rtts_pkg::CFG_MEASURE_ROUNDS, c.measure_rounds);
        write_reg(rtts_pkg::CFG_COMP_RETRIES, c.compensated_retries);
        write_reg(rtts_pkg::CFG_THR_FACTOR, c.threshold_factor);
        write_reg(rtts_pkg::CFG_MSG_TYPE, c.message_type_code);
        write_reg(rtts_pkg::CFG_ACK_CODE, c.ack_code);
        write_reg(rtts_pkg::CFG_START_CODE, c.start_code);
        write_reg(rtts_pkg::CFG_STAMP_CODE, c.timestamp_code);
        write_reg(rtts_pkg::CFG_GOOD_CODE, c.good_code);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        regs = c;
        phases_run++;
        @(negedge i_clk);
    endtask

    // Stimulus: directed cases first, then phases of random exchanges, each
    // phase under its own register setting, written while the core is idle.
    initial begin
        rtts_pkg::t_cfg c;
        int             phase_goal;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register defaults: stray timeout and reply while idle are dropped,
        // then a wrong handshake reply and a timeout while waiting.
        push_event(rtts_pkg::EV_TIMEOUT, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        push_event(rtts_pkg::EV_REPLY, 32'h0000_0000, 8'h02, 8'h00);
        push_event(rtts_pkg::EV_START, 32'h0000_0000, 8'h00, 8'hFF);
        push_event(rtts_pkg::EV_REPLY, 32'h0000_0010, 8'hFF, 8'h00);
        push_event(rtts_pkg::EV_START, 32'h0000_0020, 8'h00, 8'h00);
        push_event(rtts_pkg::EV_TIMEOUT, 32'h0000_0030, 8'h00, 8'h00);
        wait_idle();

        program_regs('{8'd2, 8'd2, 8'd24, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5});
        // Handshake across the time wrap, two measured rounds (threshold 120),
        // a round trip exactly on the threshold, then retries running out.
        push_event(rtts_pkg::EV_START, 32'h0000_0000, 8'h00, 8'hA5);
        push_event(rtts_pkg::EV_SENT, 32'hFFFF_FFF0, 8'h00, 8'h00);
        push_event(rtts_pkg::EV_REPLY, 32'h0000_0010, 8'h02, 8'h00);
        push_event(rtts_pkg::EV_SENT, 32'h0000_0100, 8'h00, 8'h00);
        push_event(rtts_pkg::EV_REPLY, 32'h0000_0164, 8'hFF, 8'h00);
        push_event(rtts_pkg::EV_SENT, 32'h0000_0200, 8'h00, 8'h00);
        push_event(rtts_pkg::EV_REPLY, 32'h0000_0250, 8'h00, 8'h00);
        push_event(rtts_pkg::EV_SENT, 32'h0000_0300, 8'h00, 8'h00);
        push_event(rtts_pkg::EV_REPLY, 32'h0000_0378, 8'h00, 8'h00);
        push_event(rtts_pkg::EV_SENT, 32'h0000_0500, 8'h00, 8'h00);
        push_event(rtts_pkg::EV_REPLY, 32'h0000_06F4, 8'h00, 8'h00);
        // Huge round trips saturate the threshold; then success and final ACK.
        push_event(rtts_pkg::EV_START, 32'hFFFF_FFFF, 8'hFF, 8'h5A);
        push_event(rtts_pkg::EV_REPLY, 32'h0000_1000, 8'h02, 8'hFF);
        push_event(rtts_pkg::EV_REPLY, 32'h0000_04FF, 8'h00, 8'h00);
        push_event(rtts_pkg::EV_REPLY, 32'h0000_04FE, 8'h00, 8'h00);
        push_event(rtts_pkg::EV_REPLY, 32'h0000_0501, 8'h00, 8'h00);
        push_event(rtts_pkg::EV_REPLY, 32'h0000_0600, 8'h02, 8'h00);
        wait_idle();

        // Upper extremes: one long clean exchange with 255 measured rounds.
        noise_on = 1'b0;
        program_regs('{8'd255, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        push_session();
        wait_idle();
        noise_on = 1'b1;

        // Lower extremes: single round, single retry, zero factor, zero codes.
        program_regs('{8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        phase_goal = events_queued + 150;
        while (events_queued < phase_goal) push_session();
        wait_idle();

        while (events_queued < 1870) begin
            c.measure_rounds      = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                                : $urandom_range(1, 8);
            c.compensated_retries = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255)
                                                                : $urandom_range(1, 8);
            c.threshold_factor    = $urandom_range(0, 255);
            c.message_type_code   = $urandom_range(0, 255);
            c.ack_code            = $urandom_range(0, 255);
            c.start_code          = $urandom_range(0, 255);
            c.timestamp_code      = $urandom_range(0, 255);
            c.good_code           = $urandom_range(0, 255);
            program_regs(c);
            phase_goal = events_queued + 200;
            while (events_queued < phase_goal) push_session();
            wait_idle();
        end

        if (words_due.size() != 0) begin
            $display("%0t ns: %0d expected result words never arrived", $time,
                     words_due.size());
            mismatches++;
        end
        $display("Ran %0d events and checked %0d result words over %0d register settings.",
                 events_accepted, words_checked, phases_run);
        $display({"Exchanges ended: %0d completed, %0d out of retries, ",
                  "%0d wrong reply, %0d timed out."},
                 seen_completed, seen_exhausted, seen_wrong, seen_timeout);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
